[sv/lfdd_pkg.sv]
package lfdd_pkg;

    // field widths
    localparam int SPEED_W   = 10;
    localparam int COUNT_W   = 16;
    localparam int ERR_W     = 11;
    localparam int IN_ERR_W  = 16;
    localparam int EMA_W     = 7;
    localparam int TICK_W    = 16;
    localparam int GAIN_W    = 6;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // filter numerator and iterative divider
    localparam int NUM_W     = 18;
    localparam int REM_W     = EMA_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // gain product and speed sums
    localparam int PROD_W    = ERR_W + GAIN_W + 1;
    localparam int ADJ_W     = 16;
    localparam int SUM_W     = ((SPEED_W > ADJ_W - 1) ? SPEED_W : ADJ_W) + 2;

    // counter compare width covers both the counter and the tick registers
    localparam int CMP_W     = (COUNT_W > TICK_W) ? COUNT_W : TICK_W;

    // stream payload
    localparam int S_TDATA_W = IN_ERR_W;
    localparam int S_TUSER_W = 2;
    localparam int OUT_BITS  = 2 + 2 * SPEED_W + 2 + 2 * ERR_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // line lost threshold on the raw error magnitude
    localparam logic signed [IN_ERR_W-1:0] LOST_HI = 16'sd999;
    localparam logic signed [IN_ERR_W-1:0] LOST_LO = -16'sd999;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMA_DIV   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN       = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH    = 8'd7;

    typedef enum logic [1:0] {
        MODE_DIFF       = 2'd0,
        MODE_SPIN_LEFT  = 2'd1,
        MODE_SPIN_RIGHT = 2'd2,
        MODE_SEARCH     = 2'd3
    } lfdd_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_WRITE,
        ST_GAIN,
        ST_SUM,
        ST_OUT
    } lfdd_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mult;
        logic div_step;
        logic write;
        logic gain;
        logic sum;
        logic out_load;
    } lfdd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic filt_req;
    } lfdd_stat_t;

endpackage

[sv/lfdd_ctrl.sv]
module lfdd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  lfdd_pkg::lfdd_stat_t stat,
    output lfdd_pkg::lfdd_cmd_t  cmd
);
    import lfdd_pkg::*;

    lfdd_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    // state, divide step count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.filt_req ? ST_MULT : ST_GAIN;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // filter updates go through the multiply and divide
    a_filt_path: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && stat.filt_req |=> state_reg == ST_MULT)
        else $error("filter update skipped the divider");

    // other transactions go straight to the gain step
    a_skip_path: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !stat.filt_req |=> state_reg == ST_GAIN)
        else $error("divider entered without a filter update");

    // divide step count stays in range
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> step_reg < STEP_W'(DIV_STEPS))
        else $error("divide step count out of range");

    // a result never overwrites one that waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !cmd.out_load)
        else $error("output register overwritten");
`endif

endmodule

[sv/lfdd_dp.sv]
module lfdd_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lfdd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [lfdd_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              cfg_write,
    input  logic [lfdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfdd_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  lfdd_pkg::lfdd_cmd_t               cmd,
    output lfdd_pkg::lfdd_stat_t              stat,
    output logic [lfdd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lfdd_pkg::*;

    // configuration
    logic [EMA_W-1:0]   ema_div_reg;
    logic [TICK_W-1:0]  timeout_reg;
    logic [TICK_W-1:0]  beat_period_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] base_reg, min_reg, max_reg, search_reg;

    // controller state
    logic signed [ERR_W-1:0] latest_reg, smooth_reg, last_good_reg, err_reg;
    logic                    lost_reg, pulse_reg;
    logic [COUNT_W-1:0]      silence_reg, beat_cnt_reg;
    logic [COUNT_W-1:0]      silence_inc, beat_inc;

    // arithmetic payload
    logic                     neg_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [REM_W-1:0]         rem_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  psum_reg, pdiff_reg;
    logic                     adj_neg_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    // input fields
    logic                       in_msg, in_err_frame;
    logic signed [IN_ERR_W-1:0] in_err;
    logic                       in_lost;

    assign in_msg       = s_tuser[0];
    assign in_err_frame = s_tuser[1];
    assign in_err       = $signed(s_tdata[IN_ERR_W-1:0]);
    assign in_lost      = (in_err >= LOST_HI) || (in_err <= LOST_LO);

    assign stat.filt_req = in_msg && in_err_frame && !in_lost;
    assign m_tdata       = m_tdata_reg;

    // effective ema divisor, zero acts as one
    logic [EMA_W-1:0] a_eff;
    assign a_eff = (ema_div_reg == '0) ? EMA_W'(1) : ema_div_reg;

    // numerator: e + s*(a-1) + a/2, then magnitude for the divider
    logic signed [NUM_W-1:0] e_ext, s_ext, am1_ext, half_ext, num;
    logic [NUM_W-1:0]        num_mag;
    always_comb begin
        e_ext    = NUM_W'(err_reg);
        s_ext    = NUM_W'(smooth_reg);
        am1_ext  = NUM_W'($signed({1'b0, a_eff - EMA_W'(1)}));
        half_ext = NUM_W'($signed({1'b0, a_eff >> 1}));
        num      = e_ext + s_ext * am1_ext + half_ext;
        num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    end

    // one restoring divide step
    logic [REM_W-1:0] rem_sh;
    logic             rem_ge;
    assign rem_sh = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, a_eff});

    // signed quotient, truncated toward zero
    logic [NUM_W-1:0] quo_signed;
    assign quo_signed = neg_reg ? (~quo_reg + NUM_W'(1)) : quo_reg;

    // saturated gain adjustment
    logic signed [ADJ_W-1:0] adj_sat;
    always_comb begin
        if (prod_reg > PROD_W'(32767)) begin
            adj_sat = 16'sh7FFF;
        end else if (prod_reg < -PROD_W'(32768)) begin
            adj_sat = -16'sh8000;
        end else begin
            adj_sat = prod_reg[ADJ_W-1:0];
        end
    end

    logic signed [SUM_W-1:0] base_ext;
    assign base_ext = SUM_W'($signed({1'b0, base_reg}));

    // clamp, low bound tested first
    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [SUM_W-1:0] v,
        input logic [SPEED_W-1:0]      lo,
        input logic [SPEED_W-1:0]      hi
    );
        logic signed [SUM_W-1:0] lo_s;
        logic signed [SUM_W-1:0] hi_s;
        lo_s = SUM_W'($signed({1'b0, lo}));
        hi_s = SUM_W'($signed({1'b0, hi}));
        if (v < lo_s) begin
            return lo;
        end else if (v > hi_s) begin
            return hi;
        end else begin
            return v[SPEED_W-1:0];
        end
    endfunction

    // result fields
    lfdd_mode_t         mode;
    logic [SPEED_W-1:0] left_sp, right_sp;
    always_comb begin
        if (lost_reg) begin
            if (last_good_reg > 0) begin
                mode = MODE_SPIN_LEFT;
            end else if (last_good_reg < 0) begin
                mode = MODE_SPIN_RIGHT;
            end else begin
                mode = MODE_SEARCH;
            end
            left_sp  = search_reg;
            right_sp = search_reg;
        end else begin
            mode = MODE_DIFF;
            if (!adj_neg_reg) begin
                left_sp  = clamp_speed(psum_reg, min_reg, max_reg);
                right_sp = clamp_speed(pdiff_reg, '0, max_reg);
            end else begin
                left_sp  = clamp_speed(psum_reg, '0, max_reg);
                right_sp = clamp_speed(pdiff_reg, min_reg, max_reg);
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_div_reg     <= EMA_W'(4);
            timeout_reg     <= TICK_W'(500);
            beat_period_reg <= TICK_W'(1000);
            gain_reg        <= GAIN_W'(1);
            base_reg        <= SPEED_W'(500);
            min_reg         <= SPEED_W'(200);
            max_reg         <= SPEED_W'(1000);
            search_reg      <= SPEED_W'(300);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_EMA_DIV:   ema_div_reg     <= cfg_data[EMA_W-1:0];
                REG_TIMEOUT:   timeout_reg     <= cfg_data[TICK_W-1:0];
                REG_HEARTBEAT: beat_period_reg <= cfg_data[TICK_W-1:0];
                REG_GAIN:      gain_reg        <= cfg_data[GAIN_W-1:0];
                REG_BASE:      base_reg        <= cfg_data[SPEED_W-1:0];
                REG_MIN:       min_reg         <= cfg_data[SPEED_W-1:0];
                REG_MAX:       max_reg         <= cfg_data[SPEED_W-1:0];
                REG_SEARCH:    search_reg      <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign silence_inc = silence_reg + COUNT_W'(1);
    assign beat_inc    = beat_cnt_reg + COUNT_W'(1);

    // tick update of errors, timeout and heartbeat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latest_reg    <= '0;
            smooth_reg    <= '0;
            last_good_reg <= '0;
            lost_reg      <= 1'b0;
            silence_reg   <= '0;
            beat_cnt_reg  <= '0;
            pulse_reg     <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (in_msg) begin
                    silence_reg <= '0;
                    if (in_err_frame) begin
                        if (in_lost) begin
                            lost_reg <= 1'b1;
                        end else begin
                            latest_reg    <= in_err[ERR_W-1:0];
                            last_good_reg <= in_err[ERR_W-1:0];
                            lost_reg      <= 1'b0;
                        end
                    end
                end else if (CMP_W'(silence_inc) >= CMP_W'(timeout_reg)) begin
                    lost_reg    <= 1'b1;
                    silence_reg <= COUNT_W'(timeout_reg);
                end else begin
                    silence_reg <= silence_inc;
                end
                if (CMP_W'(beat_inc) >= CMP_W'(beat_period_reg)) begin
                    beat_cnt_reg <= '0;
                    pulse_reg    <= 1'b1;
                end else begin
                    beat_cnt_reg <= beat_inc;
                    pulse_reg    <= 1'b0;
                end
            end
            if (cmd.write) begin
                smooth_reg <= quo_signed[ERR_W-1:0];
            end
        end
    end

    // filter and speed arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            err_reg <= in_err[ERR_W-1:0];
        end
        if (cmd.mult) begin
            neg_reg <= num[NUM_W-1];
            quo_reg <= num_mag;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, a_eff}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
        end
        if (cmd.gain) begin
            prod_reg <= PROD_W'(smooth_reg) * PROD_W'($signed({1'b0, gain_reg}));
        end
        if (cmd.sum) begin
            psum_reg    <= base_ext + SUM_W'(adj_sat);
            pdiff_reg   <= base_ext - SUM_W'(adj_sat);
            adj_neg_reg <= adj_sat[ADJ_W-1];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({latest_reg, smooth_reg, lost_reg, pulse_reg,
                                       right_sp, left_sp, mode});
        end
    end

`ifndef SYNTH
    // an in-range error frame clears the lost flag
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && stat.filt_req |=> !lost_reg)
        else $error("lost flag set after a valid error frame");

    // silence count never passes the timeout once saturated
    a_silence_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !in_msg && CMP_W'(silence_inc) >= CMP_W'(timeout_reg)
        |=> lost_reg && silence_reg == COUNT_W'($past(timeout_reg)))
        else $error("timeout did not saturate");

    // heartbeat pulse resets the beat counter
    a_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.accept) && pulse_reg |-> beat_cnt_reg == '0)
        else $error("heartbeat without counter restart");
`endif

endmodule

[sv/line_follow_differential_drive.sv]
// channel  | ports                        | transaction carries
// ---------+------------------------------+---------------------------------------
// s_       | s_tvalid s_tready s_tdata     | one tick: error value, frame flags
//          | s_tuser                      |
// m_       | m_tvalid m_tready m_tdata     | one drive result per tick
// cfg_     | cfg_valid cfg_ready cfg_index | one register write
//          | cfg_data                     |
//
// a tick with an in-range error frame runs from accept through one multiply,
// the bit-serial divider, then write, gain and sum; any other tick goes
// straight to gain and sum. a new tick is taken only after the previous
// result sits in the output register. reset (aresetn low, synchronous) loads
// the register defaults and clears the filter, timeout and heartbeat state.
// m_tready low holds the result; the next tick is then held in the output step.
module line_follow_differential_drive (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] error_value
    input  logic [lfdd_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] message_valid, [1] is_error_frame
    input  logic [lfdd_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] drive_mode, [11:2] left_wheel, [21:12] right_wheel,
    // [22] heartbeat_pulse, [23] is_offline, [34:24] smoothed_error,
    // [45:35] latest_error, [47:46] zero
    output logic [lfdd_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfdd_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import lfdd_pkg::*;

    lfdd_cmd_t  cmd;
    lfdd_stat_t stat;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    lfdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfdd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule
